FILE: rtl/itoa_pkg.sv
// Package: shared types, ASCII codes and character tables for the radix printer.
`default_nettype none

package itoa_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC  = 2'd0,
    RADIX_BIN  = 2'd1,
    RADIX_HEX  = 2'd2,
    RADIX_NONE = 2'd3
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_PREFIX0,
    ST_PREFIX1,
    ST_TEXT,
    ST_DIGITS
  } state_t;

  typedef enum logic [1:0] {
    DU_IDLE,
    DU_CONV,
    DU_SKIP,
    DU_READY
  } du_state_t;

  typedef struct packed {
    logic   load;
    logic   shift;
    radix_t mode;
  } dcmd_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
    logic       last;
  } dstat_t;

  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_LOW_B = 7'h62;
  localparam logic [6:0] CH_LOW_X = 7'h78;

  localparam int         TEXT_LEN  = 19;
  localparam logic [4:0] TEXT_LAST = 5'(TEXT_LEN - 1);

  function automatic logic [6:0] hex_glyph(input logic [3:0] d);
    logic [6:0] g;
    if (d < 4'd10) begin
      g = 7'h30 + {3'b000, d};
    end else begin
      g = 7'h37 + {3'b000, d};
    end
    return g;
  endfunction

  // "Base not supported\n"
  function automatic logic [6:0] text_char(input logic [4:0] idx);
    logic [6:0] c;
    unique case (idx)
      5'd0:    c = 7'h42;
      5'd1:    c = 7'h61;
      5'd2:    c = 7'h73;
      5'd3:    c = 7'h65;
      5'd4:    c = 7'h20;
      5'd5:    c = 7'h6E;
      5'd6:    c = 7'h6F;
      5'd7:    c = 7'h74;
      5'd8:    c = 7'h20;
      5'd9:    c = 7'h73;
      5'd10:   c = 7'h75;
      5'd11:   c = 7'h70;
      5'd12:   c = 7'h70;
      5'd13:   c = 7'h6F;
      5'd14:   c = 7'h72;
      5'd15:   c = 7'h74;
      5'd16:   c = 7'h65;
      5'd17:   c = 7'h64;
      5'd18:   c = 7'h0A;
      default: c = 7'h0A;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/itoa_in_if.sv
// Interface: number request channel (value, signed flag, base code).
`default_nettype none

interface itoa_in_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  is_signed;
  logic [1:0]            radix_mode;

  modport source (output valid, output value, output is_signed, output radix_mode,
                  input ready);
  modport sink   (input valid, input value, input is_signed, input radix_mode,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/itoa_out_if.sv
// Interface: character request channel (char_out, last).
`default_nettype none

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/itoa_digit_unit.sv
// Digit unit: bit-serial double-dabble conversion and MSB-first digit shift register.
`default_nettype none

module itoa_digit_unit #(
  parameter int VB = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  itoa_pkg::dcmd_t  cmd,
  input  logic [VB-1:0]    mag,
  output itoa_pkg::dstat_t stat
);
  import itoa_pkg::*;

  localparam int DIGITS     = (VB * 30103) / 100000 + 1;
  localparam int W          = 4 * DIGITS;
  localparam int HEX_DIGITS = (VB + 3) / 4;
  localparam int HEX_W      = 4 * HEX_DIGITS;
  localparam int CW         = $clog2(VB + 1);

  du_state_t     state, state_next;
  radix_t        mode_r;
  logic [VB-1:0] work;
  logic [W-1:0]  dig;
  logic [W-1:0]  adj;
  logic [W-1:0]  shifted;
  logic [CW-1:0] cnt;
  logic [CW-1:0] bit_cnt;
  logic [3:0]    top;
  logic          skip_ok;

  always_comb begin
    adj = dig;
    for (int i = 0; i < DIGITS; i++) begin
      if (dig[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      end
    end
  end

  assign top     = (mode_r == RADIX_BIN) ? {3'b000, dig[W-1]} : dig[W-1 -: 4];
  assign shifted = (mode_r == RADIX_BIN) ? (dig << 1) : (dig << 4);
  assign skip_ok = (top == 4'd0) && (cnt > CW'(1));

  always_comb begin
    state_next = state;
    if (cmd.load) begin
      unique case (cmd.mode)
        RADIX_DEC:            state_next = DU_CONV;
        RADIX_BIN, RADIX_HEX: state_next = DU_SKIP;
        RADIX_NONE:           state_next = DU_IDLE;
      endcase
    end else begin
      unique case (state)
        DU_IDLE:  state_next = DU_IDLE;
        DU_CONV:  if (bit_cnt == CW'(1)) state_next = DU_SKIP;
        DU_SKIP:  if (!skip_ok) state_next = DU_READY;
        DU_READY: if (cmd.shift && cnt == CW'(1)) state_next = DU_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      bit_cnt <= '0;
    end else if (cmd.load) begin
      mode_r  <= cmd.mode;
      work    <= mag;
      bit_cnt <= CW'(VB);
      unique case (cmd.mode)
        RADIX_DEC: begin
          dig <= '0;
          cnt <= CW'(DIGITS);
        end
        RADIX_BIN: begin
          dig <= W'(mag) << (W - VB);
          cnt <= CW'(VB);
        end
        RADIX_HEX, RADIX_NONE: begin
          dig <= W'(mag) << (W - HEX_W);
          cnt <= CW'(HEX_DIGITS);
        end
      endcase
    end else begin
      unique case (state)
        DU_IDLE: ;
        DU_CONV: begin
          dig     <= {adj[W-2:0], work[VB-1]};
          work    <= work << 1;
          bit_cnt <= bit_cnt - CW'(1);
        end
        DU_SKIP: if (skip_ok) begin
          dig <= shifted;
          cnt <= cnt - CW'(1);
        end
        DU_READY: if (cmd.shift) begin
          dig <= shifted;
          cnt <= cnt - CW'(1);
        end
      endcase
    end
  end

  always_comb begin
    stat.valid = (state == DU_READY);
    stat.digit = top;
    stat.last  = (cnt == CW'(1));
  end

`ifndef SYNTHESIS
  a_shift_when_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> state == DU_READY)
    else $error("digit shift outside ready state");
  a_ready_has_digits: assert property (@(posedge clk) disable iff (rst)
    state == DU_READY |-> cnt != '0)
    else $error("ready with no digits left");
  a_conv_has_bits: assert property (@(posedge clk) disable iff (rst)
    state == DU_CONV |-> bit_cnt != '0)
    else $error("conversion with no bits left");
`endif

endmodule

`default_nettype wire

FILE: rtl/itoa_ctrl.sv
// Control: request intake, sign/prefix/text sequencing and the output register.
`default_nettype none

module itoa_ctrl #(
  parameter int VB = 32
) (
  input  logic             clk,
  input  logic             rst,
  itoa_in_if.sink          number,
  itoa_out_if.source       text,
  output itoa_pkg::dcmd_t  cmd,
  output logic [VB-1:0]    mag,
  input  itoa_pkg::dstat_t stat
);
  import itoa_pkg::*;

  state_t     state, state_next;
  radix_t     mode_in;
  radix_t     mode_r;
  logic [4:0] text_idx;
  logic       accept;
  logic       neg;
  logic       slot_free;
  logic       emit;
  logic       emit_last;
  logic [6:0] emit_char;
  logic       out_valid;
  logic [6:0] out_char;
  logic       out_last;

  function automatic state_t body_state(input radix_t m);
    state_t s;
    unique case (m)
      RADIX_DEC:            s = ST_DIGITS;
      RADIX_BIN, RADIX_HEX: s = ST_PREFIX0;
      RADIX_NONE:           s = ST_TEXT;
    endcase
    return s;
  endfunction

  assign mode_in      = radix_t'(number.radix_mode);
  assign number.ready = (state == ST_IDLE);
  assign accept       = number.valid && number.ready;
  assign neg          = number.is_signed && number.value[VB-1];
  assign mag          = neg ? (~number.value + VB'(1)) : number.value;
  assign slot_free    = !out_valid || text.ready;

  always_comb begin
    emit      = 1'b0;
    emit_char = CH_ZERO;
    emit_last = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_SIGN: begin
        emit      = slot_free;
        emit_char = CH_MINUS;
      end
      ST_PREFIX0: begin
        emit      = slot_free;
        emit_char = CH_ZERO;
      end
      ST_PREFIX1: begin
        emit      = slot_free;
        emit_char = (mode_r == RADIX_BIN) ? CH_LOW_B : CH_LOW_X;
      end
      ST_TEXT: begin
        emit      = slot_free;
        emit_char = text_char(text_idx);
        emit_last = (text_idx == TEXT_LAST);
      end
      ST_DIGITS: begin
        emit      = slot_free && stat.valid;
        emit_char = hex_glyph(stat.digit);
        emit_last = stat.last;
      end
    endcase
  end

  always_comb begin
    cmd.load  = accept;
    cmd.shift = emit && (state == ST_DIGITS);
    cmd.mode  = mode_in;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = neg ? ST_SIGN : body_state(mode_in);
      ST_SIGN:    if (emit) state_next = body_state(mode_r);
      ST_PREFIX0: if (emit) state_next = ST_PREFIX1;
      ST_PREFIX1: if (emit) state_next = ST_DIGITS;
      ST_TEXT:    if (emit && emit_last) state_next = ST_IDLE;
      ST_DIGITS:  if (emit && emit_last) state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      text_idx <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        text_idx <= '0;
      end else if (emit && state == ST_TEXT) begin
        text_idx <= text_idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  assign text.valid    = out_valid;
  assign text.char_out = out_char;
  assign text.last     = out_last;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");
  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |=> state == ST_IDLE)
    else $error("last character did not end the item");
  a_text_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_TEXT |-> text_idx <= TEXT_LAST)
    else $error("text index past end of message");
`endif

endmodule

`default_nettype wire

FILE: rtl/integer_to_ascii_radix_printer.sv
// Top level: integer to ASCII printer in decimal, binary or hex.
// Usage:
//   number: one request per integer (value, is_signed, radix_mode), taken
//           only once the earlier integer's last character is in the output register.
//   text:   one request per ASCII character, most significant digit first,
//           last set on the final character of each integer.
//   Sign '-' and the "0b"/"0x" prefix go out while the digit unit works.
//   Decimal digits come from a bit-serial double-dabble pass over the
//   VALUE_BITS input bits, then leading zero digits are dropped, keeping at
//   least one digit; binary and hex only drop leading zeros.
//   The next integer can be taken the cycle after the last character is loaded
//   into the output register, while that character may still wait.
//   Base code 3 prints "Base not supported" and a newline.
//   Reset (rst, synchronous) empties the output register and returns both
//   sequencers to idle. A stalled receiver holds the output register and
//   pauses the character sequence; nothing is dropped.
`default_nettype none

module integer_to_ascii_radix_printer #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  itoa_in_if.sink    number,
  itoa_out_if.source text
);
  import itoa_pkg::*;

  dcmd_t                 cmd;
  dstat_t                stat;
  logic [VALUE_BITS-1:0] mag;

  itoa_ctrl #(.VB(VALUE_BITS)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .number (number),
    .text   (text),
    .cmd    (cmd),
    .mag    (mag),
    .stat   (stat)
  );

  itoa_digit_unit #(.VB(VALUE_BITS)) u_digits (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .mag  (mag),
    .stat (stat)
  );

endmodule

`default_nettype wire

FILE: dv/tb_integer_to_ascii_radix_printer.sv
// Testbench: integer to ASCII radix printer, checked per character by a scoreboard.
`timescale 1ns / 100ps

module tb_integer_to_ascii_radix_printer;
  import itoa_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD = 400;

  class char_scoreboard;
    logic [6:0] exp_char[$];
    logic       exp_last[$];
    int         errors;

    function void put(byte c);
      exp_char.push_back(c[6:0]);
      exp_last.push_back(1'b0);
    endfunction

    function void note_request(logic [31:0] v, logic sgn, radix_t mode);
      logic [31:0] mag;
      logic [3:0]  digs[$];
      int          base;
      string       glyphs;
      string       msg;
      glyphs = "0123456789ABCDEF";
      msg = "Base not supported\n";
      mag = v;
      if (sgn && v[31]) begin
        put("-");
        mag = -v;
      end
      if (mode == RADIX_NONE) begin
        for (int i = 0; i < msg.len(); i++) put(msg[i]);
      end else begin
        case (mode)
          RADIX_BIN: begin
            put("0");
            put("b");
            base = 2;
          end
          RADIX_HEX: begin
            put("0");
            put("x");
            base = 16;
          end
          default: base = 10;
        endcase
        if (mag == 32'd0) digs.push_front(4'd0);
        while (mag != 32'd0) begin
          digs.push_front(4'(mag % base));
          mag = mag / base;
        end
        foreach (digs[i]) put(glyphs[digs[i]]);
      end
      exp_last[exp_last.size() - 1] = 1'b1;
    endfunction

    function void check_char(logic [6:0] ch, logic lst);
      logic [6:0] want_ch;
      logic       want_last;
      if (exp_char.size() == 0) begin
        $error("unexpected character %h (last %b)", ch, lst);
        errors++;
        return;
      end
      want_ch = exp_char.pop_front();
      want_last = exp_last.pop_front();
      if (ch !== want_ch) begin
        $error("char_out: expected %h, got %h", want_ch, ch);
        errors++;
      end
      if (lst !== want_last) begin
        $error("last: expected %b, got %b", want_last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return exp_char.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  itoa_in_if #(.VALUE_BITS(32)) number_if();
  itoa_out_if text_if();

  integer_to_ascii_radix_printer #(.VALUE_BITS(32)) dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_if),
    .text   (text_if)
  );

  char_scoreboard board;
  int src_style;
  int snk_style;
  int stall_left;
  int quiet_cycles;
  bit long_hold;

  always #10 clk = ~clk;

  // style 0: no gaps, 1: light, 2: heavy
  function automatic int draw_gap(int style);
    int r;
    if (style == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < ((style == 2) ? 40 : 70)) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] draw_value();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(0, 999);
      2: return 32'd1 << k;
      3: return (32'd1 << k) - 32'd1;
      4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      5: return 32'h8000_0000 + $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic radix_t draw_radix();
    if ($urandom_range(0, 9) == 0) return RADIX_NONE;
    return radix_t'($urandom_range(0, 2));
  endfunction

  // called and returns at a falling edge
  task automatic offer_number(logic [31:0] v, logic sgn, radix_t mode);
    int gap;
    gap = draw_gap(src_style);
    if (gap > 0) begin
      number_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    number_if.valid <= 1'b1;
    number_if.value <= v;
    number_if.is_signed <= sgn;
    number_if.radix_mode <= mode;
    do @(posedge clk); while (!number_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    number_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        stall_left = LONG_HOLD;
        long_hold = 1'b0;
      end
      if (stall_left > 0) begin
        text_if.ready <= 1'b0;
        stall_left--;
      end else begin
        text_if.ready <= 1'b1;
        stall_left = draw_gap(snk_style);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (number_if.valid && number_if.ready)
        board.note_request(number_if.value, number_if.is_signed,
                           radix_t'(number_if.radix_mode));
      if (text_if.valid && text_if.ready)
        board.check_char(text_if.char_out, text_if.last);
      if ((number_if.valid && number_if.ready) || (text_if.valid && text_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_integer_to_ascii_radix_printer NOT OK");
        $finish;
      end
    end
  end

  initial begin
    number_if.valid = 1'b0;
    number_if.value = '0;
    number_if.is_signed = 1'b0;
    number_if.radix_mode = RADIX_DEC;
    text_if.ready = 1'b0;
    board = new();
    src_style = 1;
    snk_style = 1;
    stall_left = 0;
    quiet_cycles = 0;
    long_hold = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero, extremes, most negative, unsupported base
    offer_number(32'd0, 1'b0, RADIX_DEC);
    offer_number(32'd0, 1'b1, RADIX_BIN);
    offer_number(32'd0, 1'b0, RADIX_HEX);
    offer_number(32'd0, 1'b0, RADIX_NONE);
    offer_number(32'hFFFF_FFFF, 1'b0, RADIX_DEC);
    offer_number(32'hFFFF_FFFF, 1'b0, RADIX_BIN);
    offer_number(32'hFFFF_FFFF, 1'b0, RADIX_HEX);
    offer_number(32'hFFFF_FFFF, 1'b0, RADIX_NONE);
    offer_number(32'h8000_0000, 1'b1, RADIX_DEC);
    offer_number(32'h8000_0000, 1'b1, RADIX_BIN);
    offer_number(32'h8000_0000, 1'b1, RADIX_HEX);
    offer_number(32'h8000_0000, 1'b1, RADIX_NONE);
    offer_number(32'h8000_0000, 1'b0, RADIX_DEC);
    offer_number(32'hFFFF_FFFF, 1'b1, RADIX_DEC);
    offer_number(32'hFFFF_FFFF, 1'b1, RADIX_HEX);
    offer_number(32'h7FFF_FFFF, 1'b1, RADIX_DEC);
    offer_number(32'd123456789, 1'b1, RADIX_DEC);
    offer_number(32'd9, 1'b0, RADIX_DEC);
    offer_number(32'd10, 1'b0, RADIX_DEC);
    offer_number(32'd15, 1'b0, RADIX_HEX);
    offer_number(32'd16, 1'b0, RADIX_HEX);
    offer_number(32'd1, 1'b0, RADIX_BIN);
    offer_number(32'hFFFF_FFF6, 1'b1, RADIX_BIN);
    drain();

    for (int chunk = 0; chunk < 10; chunk++) begin
      src_style = $urandom_range(0, 2);
      snk_style = $urandom_range(0, 2);
      if (chunk == 3) long_hold = 1'b1;
      if (chunk == 6) drain();
      for (int i = 0; i < 36; i++)
        offer_number(draw_value(), 1'($urandom_range(0, 1)), draw_radix());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_integer_to_ascii_radix_printer OK");
    end else begin
      $display("tb_integer_to_ascii_radix_printer NOT OK");
    end
    $finish;
  end

endmodule

FILE: integer_to_ascii_radix_printer.f
rtl/itoa_pkg.sv
rtl/itoa_in_if.sv
rtl/itoa_out_if.sv
rtl/itoa_digit_unit.sv
rtl/itoa_ctrl.sv
rtl/integer_to_ascii_radix_printer.sv
dv/tb_integer_to_ascii_radix_printer.sv
